[rtl/qpsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsc_pkg
// shared types and constants of the quadrature position and speed counter
// ----------------------------------------------------------------------------
package qpsc_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int GLITCH_BITS    = 10;
    localparam int COUNT_BITS     = 16;
    localparam int RPM_BITS       = 32;

    // 60e6 us per minute times 256 for the q8 fraction
    localparam int                SCALE_CHUNK_BITS = 16;
    localparam int                SCALE_CHUNKS     = 3;
    localparam logic [47:0]       RPM_SCALE        = 48'd15360000000;

    typedef enum logic [2:0] {
        FN_PIN_SAMPLE = 3'd0,
        FN_SPEED      = 3'd1,
        FN_CLEAR      = 3'd2,
        FN_STOP       = 3'd3,
        FN_START      = 3'd4
    } func_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_UPPER_FOLD     = 2'd0,
        CFG_LOWER_FOLD     = 2'd1,
        CFG_COUNTS_PER_REV = 2'd2,
        CFG_GLITCH_SAMPLES = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [14:0]            upper_fold;
        logic signed [15:0]     lower_fold;
        logic [15:0]            counts_per_rev;
        logic [GLITCH_BITS-1:0] glitch_samples;
    } cfg_t;

endpackage

[rtl/qpsc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsc_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface qpsc_in_if #(
    parameter int TIME_BITS = 40
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           func;
    logic                 pin_a;
    logic                 pin_b;
    logic [TIME_BITS-1:0] time_us;

    modport source (output valid, output func, output pin_a, output pin_b,
                    output time_us, input ready);
    modport sink   (input valid, input func, input pin_a, input pin_b,
                    input time_us, output ready);
endinterface

interface qpsc_out_if #(
    parameter int POSITION_BITS = 48
);
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] position;
    logic signed [15:0]              raw_count;
    logic signed [31:0]              rpm_q8;
    logic                            status;

    modport source (output valid, output position, output raw_count,
                    output rpm_q8, output status, input ready);
    modport sink   (input valid, input position, input raw_count,
                    input rpm_q8, input status, output ready);
endinterface

[rtl/qpsc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsc_fifo
// small register queue between the counting front and the speed back end
// ----------------------------------------------------------------------------
module qpsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/qpsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsc_front
// glitch filters, x4 edge decoding, limited counter and position tracking
// ----------------------------------------------------------------------------
module qpsc_front #(
    parameter int POSITION_BITS = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qpsc_pkg::cfg_t           cfg,
    input  logic                     take,
    input  logic [2:0]               func,
    input  logic                     pin_a,
    input  logic                     pin_b,
    output logic [POSITION_BITS-1:0] position,
    output logic [15:0]              raw_count
);
    localparam int GB = qpsc_pkg::GLITCH_BITS;

    typedef struct packed {
        logic          level;
        logic [GB-1:0] run;
        logic          hit;
    } filt_t;

    function automatic filt_t filter_pin(input logic raw, input logic level,
                                         input logic [GB-1:0] run,
                                         input logic [GB-1:0] need);
        filt_t   r;
        logic [GB:0] run_inc;
        run_inc = {1'b0, run} + 1'b1;
        r.level = level;
        r.run   = '0;
        r.hit   = 1'b0;
        if (raw != level)
        begin
            if (run_inc >= {1'b0, need})
            begin
                r.level = raw;
                r.hit   = 1'b1;
            end
            else
            begin
                r.run = run_inc[GB-1:0];
            end
        end
        return r;
    endfunction

    logic                     level_a_reg, level_a_next;
    logic                     level_b_reg, level_b_next;
    logic [GB-1:0]            run_a_reg, run_a_next;
    logic [GB-1:0]            run_b_reg, run_b_next;
    logic signed [15:0]       count_reg, count_next;
    logic [POSITION_BITS-1:0] acc_reg, acc_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     running_reg, running_next;

    filt_t                    fa, fb;
    logic                     up, do_count, fold;
    logic signed [16:0]       count_sum;
    logic [POSITION_BITS-1:0] pos_step;

    assign fa = filter_pin(pin_a, level_a_reg, run_a_reg, cfg.glitch_samples);
    assign fb = filter_pin(pin_b, level_b_reg, run_b_reg, cfg.glitch_samples);

    // direction of the accepted edge, judged against the other channel's old level
    assign up        = fa.hit ? (fa.level == level_b_reg) : (fb.level != level_a_reg);
    assign do_count  = running_reg && (fa.hit ^ fb.hit);
    assign count_sum = {count_reg[15], count_reg} + (up ? 17'sd1 : -17'sd1);
    assign fold      = (count_sum >= $signed({2'b00, cfg.upper_fold}))
                    || (count_sum <= $signed({cfg.lower_fold[15], cfg.lower_fold}));
    assign pos_step  = pos_reg + {{(POSITION_BITS-1){!up}}, 1'b1};

    always_comb
    begin
        level_a_next = level_a_reg;
        level_b_next = level_b_reg;
        run_a_next   = run_a_reg;
        run_b_next   = run_b_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        running_next = running_reg;
        if (take)
        begin
            case (func)
                qpsc_pkg::FN_PIN_SAMPLE:
                begin
                    level_a_next = fa.level;
                    level_b_next = fb.level;
                    run_a_next   = fa.run;
                    run_b_next   = fb.run;
                    if (do_count)
                    begin
                        pos_next = pos_step;
                        if (fold)
                        begin
                            acc_next   = pos_step;
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_sum[15:0];
                        end
                    end
                end
                qpsc_pkg::FN_CLEAR:
                begin
                    count_next = '0;
                    pos_next   = acc_reg;
                end
                qpsc_pkg::FN_STOP:  running_next = 1'b0;
                qpsc_pkg::FN_START: running_next = 1'b1;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_a_reg <= 1'b0;
            level_b_reg <= 1'b0;
            run_a_reg   <= '0;
            run_b_reg   <= '0;
            count_reg   <= '0;
            acc_reg     <= '0;
            pos_reg     <= '0;
            running_reg <= 1'b1;
        end
        else
        begin
            level_a_reg <= level_a_next;
            level_b_reg <= level_b_next;
            run_a_reg   <= run_a_next;
            run_b_reg   <= run_b_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            pos_reg     <= pos_next;
            running_reg <= running_next;
        end
    end

    assign position  = pos_next;
    assign raw_count = count_next;

endmodule

[rtl/qpsc_speed.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsc_speed
// result stage: speed from position and time deltas by bit-serial division
// ----------------------------------------------------------------------------
module qpsc_speed #(
    parameter int POSITION_BITS = 48,
    parameter int TIME_BITS     = 40
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [15:0]              counts_per_rev,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  logic                     q_speed,
    input  logic [TIME_BITS-1:0]     q_time,
    input  logic [POSITION_BITS-1:0] q_position,
    input  logic [15:0]              q_raw_count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [POSITION_BITS-1:0] out_position,
    output logic [15:0]              out_raw_count,
    output logic [31:0]              out_rpm_q8,
    output logic                     out_status
);
    localparam int P     = POSITION_BITS;
    localparam int T     = TIME_BITS;
    localparam int CB    = qpsc_pkg::SCALE_CHUNK_BITS;
    localparam int NUM_W = P + 33;
    localparam int DEN_W = T + 15;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    state_t         state_reg, state_next;
    logic [P-1:0]   last_pos_reg, last_pos_next;
    logic [T-1:0]   last_time_reg, last_time_next;
    logic [P-1:0]   dp_reg, dp_next;
    logic [T-2:0]   dt_reg, dt_next;
    logic           neg_reg, neg_next;
    logic [P-1:0]   mag_reg, mag_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [31:0]    quo_reg, quo_next;
    logic           sat_reg, sat_next;
    logic [1:0]     chunk_reg, chunk_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           ov_reg, ov_next;
    logic [P-1:0]   opos_reg, opos_next;
    logic [15:0]    oraw_reg, oraw_next;
    logic [31:0]    orpm_reg, orpm_next;
    logic           ostat_reg, ostat_next;
    logic [P-1:0]   hpos_reg, hpos_next;
    logic [15:0]    hraw_reg, hraw_next;

    logic           out_free;
    logic [P-1:0]   dp_now;
    logic [T-1:0]   dt_now;
    logic [15:0]    cpr_eff;
    logic [CB-1:0]  chunk_val;
    logic [P+CB-1:0] part;
    logic [DEN_W:0] rem_shift;
    logic           qbit;
    logic           over;

    assign out_free  = !ov_reg || out_ready;
    assign dp_now    = q_position - last_pos_reg;
    assign dt_now    = q_time - last_time_reg;
    assign cpr_eff   = (counts_per_rev == '0) ? 16'd1 : counts_per_rev;
    assign chunk_val = qpsc_pkg::RPM_SCALE[chunk_reg*CB +: CB];
    assign part      = mag_reg * chunk_val;
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign qbit      = (rem_shift >= {1'b0, den_reg});
    assign over      = sat_reg || quo_reg[31];

    always_comb
    begin
        state_next     = state_reg;
        last_pos_next  = last_pos_reg;
        last_time_next = last_time_reg;
        dp_next        = dp_reg;
        dt_next        = dt_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        sat_next       = sat_reg;
        chunk_next     = chunk_reg;
        cnt_next       = cnt_reg;
        ov_next        = ov_reg;
        opos_next      = opos_reg;
        oraw_next      = oraw_reg;
        orpm_next      = orpm_reg;
        ostat_next     = ostat_reg;
        hpos_next      = hpos_reg;
        hraw_next      = hraw_reg;
        q_pop          = 1'b0;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (!q_speed)
                    begin
                        ov_next    = 1'b1;
                        opos_next  = q_position;
                        oraw_next  = q_raw_count;
                        orpm_next  = '0;
                        ostat_next = 1'b0;
                    end
                    else
                    begin
                        last_pos_next  = q_position;
                        last_time_next = q_time;
                        hpos_next      = q_position;
                        hraw_next      = q_raw_count;
                        dp_next        = dp_now;
                        dt_next        = dt_now[T-2:0];
                        if (dt_now == '0 || dt_now[T-1])
                        begin
                            ov_next    = 1'b1;
                            opos_next  = q_position;
                            oraw_next  = q_raw_count;
                            orpm_next  = '0;
                            ostat_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_PREP;
                        end
                    end
                end
            end
            S_PREP:
            begin
                neg_next   = dp_reg[P-1];
                mag_next   = dp_reg[P-1] ? (~dp_reg + 1'b1) : dp_reg;
                den_next   = DEN_W'(dt_reg * cpr_eff);
                num_next   = '0;
                chunk_next = 2'(qpsc_pkg::SCALE_CHUNKS - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                num_next = {num_reg[NUM_W-CB-1:0], {CB{1'b0}}} + NUM_W'(part);
                if (chunk_reg == '0)
                begin
                    rem_next   = '0;
                    quo_next   = '0;
                    sat_next   = 1'b0;
                    cnt_next   = CNT_W'(NUM_W - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    chunk_next = chunk_reg - 1'b1;
                end
            end
            S_DIV:
            begin
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                rem_next = qbit ? DEN_W'(rem_shift - {1'b0, den_reg})
                                : rem_shift[DEN_W-1:0];
                sat_next = sat_reg || quo_reg[31];
                quo_next = {quo_reg[30:0], qbit};
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    opos_next  = hpos_reg;
                    oraw_next  = hraw_reg;
                    ostat_next = 1'b0;
                    if (neg_reg)
                    begin
                        orpm_next = over ? 32'h8000_0000 : (~quo_reg + 1'b1);
                    end
                    else
                    begin
                        orpm_next = over ? 32'h7FFF_FFFF : quo_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_pos_reg  <= '0;
            last_time_reg <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_pos_reg  <= last_pos_next;
            last_time_reg <= last_time_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dp_reg    <= dp_next;
        dt_reg    <= dt_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        sat_reg   <= sat_next;
        chunk_reg <= chunk_next;
        cnt_reg   <= cnt_next;
        opos_reg  <= opos_next;
        oraw_reg  <= oraw_next;
        orpm_reg  <= orpm_next;
        ostat_reg <= ostat_next;
        hpos_reg  <= hpos_next;
        hraw_reg  <= hraw_next;
    end

    assign out_valid     = ov_reg;
    assign out_position  = opos_reg;
    assign out_raw_count = oraw_reg;
    assign out_rpm_q8    = orpm_reg;
    assign out_status    = ostat_reg;

endmodule

[rtl/quadrature_position_speed_counter_unit.sv]
`timescale 1ns / 1ps
// path: pin samples and commands pass through the queue and then the output register of the result stage
// speed request: steps S_PREP, S_MUL, S_DIV and S_FIN in turn, with the
// one-bit-per-cycle divider in S_DIV; it holds the result stage while it runs
// throughput: one item per cycle while no speed request is in flight and out_ch.ready stays high
// reset: all counting state, speed history and config registers to defaults at once
// ----------------------------------------------------------------------------
// quadrature_position_speed_counter_unit
// x4 quadrature counter with limit folding and rpm speed requests
// ----------------------------------------------------------------------------
module quadrature_position_speed_counter_unit #(
    parameter int POSITION_BITS = 48,
    parameter int TIME_BITS     = 40,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    qpsc_in_if.sink                                in_ch,
    qpsc_out_if.source                             out_ch,
    input  logic                                   cfg_we,
    input  logic [qpsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [qpsc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    localparam int ENTRY_W = 1 + TIME_BITS + 16 + POSITION_BITS;

    qpsc_pkg::cfg_t           cfg_reg;
    logic                     take;
    logic                     q_full, q_empty, q_pop;
    logic [ENTRY_W-1:0]       q_in, q_out;
    logic [POSITION_BITS-1:0] f_position;
    logic [15:0]              f_raw_count;
    logic                     e_speed;
    logic [TIME_BITS-1:0]     e_time;
    logic [15:0]              e_raw_count;
    logic [POSITION_BITS-1:0] e_position;
    logic [POSITION_BITS-1:0] o_position;
    logic [15:0]              o_raw_count;
    logic [31:0]              o_rpm_q8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_fold     <= 15'd30000;
            cfg_reg.lower_fold     <= -16'sd30000;
            cfg_reg.counts_per_rev <= 16'd2400;
            cfg_reg.glitch_samples <= 10'd80;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qpsc_pkg::CFG_UPPER_FOLD:     cfg_reg.upper_fold     <= cfg_data[14:0];
                qpsc_pkg::CFG_LOWER_FOLD:     cfg_reg.lower_fold     <= cfg_data;
                qpsc_pkg::CFG_COUNTS_PER_REV: cfg_reg.counts_per_rev <= cfg_data;
                qpsc_pkg::CFG_GLITCH_SAMPLES: cfg_reg.glitch_samples <= cfg_data[9:0];
                default:                      ;
            endcase
        end
    end

    assign in_ch.ready = !q_full;
    assign take        = in_ch.valid && !q_full;

    qpsc_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .func      (in_ch.func),
        .pin_a     (in_ch.pin_a),
        .pin_b     (in_ch.pin_b),
        .position  (f_position),
        .raw_count (f_raw_count)
    );

    assign q_in = {(in_ch.func == qpsc_pkg::FN_SPEED), in_ch.time_us, f_raw_count, f_position};

    qpsc_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign {e_speed, e_time, e_raw_count, e_position} = q_out;

    qpsc_speed #(
        .POSITION_BITS (POSITION_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_speed (
        .clk            (clk),
        .rst_n          (rst_n),
        .counts_per_rev (cfg_reg.counts_per_rev),
        .q_valid        (!q_empty),
        .q_pop          (q_pop),
        .q_speed        (e_speed),
        .q_time         (e_time),
        .q_position     (e_position),
        .q_raw_count    (e_raw_count),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_position   (o_position),
        .out_raw_count  (o_raw_count),
        .out_rpm_q8     (o_rpm_q8),
        .out_status     (out_ch.status)
    );

    assign out_ch.position  = o_position;
    assign out_ch.raw_count = o_raw_count;
    assign out_ch.rpm_q8    = o_rpm_q8;

endmodule
